[sv/tgarle_pkg.sv]
`timescale 1ns / 1ps

package tgarle_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PIX_W       = 32;
    localparam int unsigned RUN_W       = 8;
    localparam int unsigned COUNT_W     = 30;
    localparam int unsigned FMT_W       = 2;
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = CFG_IDX_W'(1);

    // Pixel formats
    localparam logic [FMT_W-1:0] FMT_GRAY = FMT_W'(0);
    localparam logic [FMT_W-1:0] FMT_RGB  = FMT_W'(1);
    localparam logic [FMT_W-1:0] FMT_RGBA = FMT_W'(2);

    localparam logic [COUNT_W-1:0] COUNT_RESET  = COUNT_W'(1);
    localparam logic [FMT_W-1:0]   FORMAT_RESET = FMT_RGBA;

    // Repeat packet count is header minus this base
    localparam logic [BYTE_W-1:0] REPEAT_BASE = BYTE_W'(127);

    // One completed pixel as handed from front to back
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [RUN_W-1:0] run;
        logic             packet_ends;
    } pix_evt_t;

    // Restart control from the configuration decoder
    typedef struct packed {
        logic               clear;
        logic [COUNT_W-1:0] count;
    } ctl_t;

    // Index of the last byte of a pixel for a given format
    function automatic logic [1:0] last_byte_idx(input logic [FMT_W-1:0] fmt);
        logic [1:0] idx;
        case (fmt)
            FMT_GRAY: idx = 2'd0;
            FMT_RGB:  idx = 2'd2;
            default:  idx = 2'd3;
        endcase
        return idx;
    endfunction

endpackage

[sv/tgarle_ifs.sv]
`timescale 1ns / 1ps

interface tgarle_stream_if;
    logic                            valid;
    logic                            ready;
    logic [tgarle_pkg::BYTE_W-1:0]   stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface tgarle_pixel_if;
    logic                            valid;
    logic                            ready;
    logic [tgarle_pkg::PIX_W-1:0]    pixel_value;
    logic [tgarle_pkg::RUN_W-1:0]    run_length;
    logic                            image_done;
    logic                            overflow_error;

    modport source (output valid, output pixel_value, output run_length,
                    output image_done, output overflow_error, input ready);
    modport sink   (input valid, input pixel_value, input run_length,
                    input image_done, input overflow_error, output ready);
endinterface

interface tgarle_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tgarle_pkg::CFG_IDX_W-1:0]    index;
    logic [tgarle_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/tgarle_queue.sv]
`timescale 1ns / 1ps

module tgarle_queue #(
    parameter int unsigned DEPTH  = tgarle_pkg::QUEUE_DEPTH,
    parameter int unsigned DATA_W = $bits(tgarle_pkg::pix_evt_t)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              space,
    input  logic              pop,
    output logic              pop_valid,
    output logic [DATA_W-1:0] pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign space     = (count_reg != FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && space;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (clear)
        begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push && !clear)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_full_no_space: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == FULL_CNT) |-> !space)
        else $error("queue offers space while full");

endmodule

[sv/tgarle_front.sv]
`timescale 1ns / 1ps

module tgarle_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic [tgarle_pkg::FMT_W-1:0]      pixel_format,
    tgarle_stream_if.sink                     stream,
    input  logic                              q_space,
    output logic                              q_push,
    output tgarle_pkg::pix_evt_t              q_data
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_PIXEL  = 2'b10
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [tgarle_pkg::RUN_W-1:0]        rem_reg, rem_next;
    logic                                repeat_reg, repeat_next;
    logic [1:0]                          idx_reg, idx_next;
    logic [tgarle_pkg::PIX_W-1:0]        asm_reg, asm_next;
    logic [tgarle_pkg::PIX_W-1:0]        merged;
    logic                                accept;
    logic                                last_byte;
    logic [tgarle_pkg::BYTE_W-1:0]       b;

    assign stream.ready = q_space;
    assign accept       = stream.valid && q_space;
    assign b            = stream.stream_byte;
    assign last_byte    = (idx_reg == tgarle_pkg::last_byte_idx(pixel_format));

    always_comb
    begin
        merged = asm_reg;
        merged[{idx_reg, 3'b000} +: tgarle_pkg::BYTE_W] = b;
    end

    always_comb
    begin
        q_data.pixel       = merged;
        q_data.run         = repeat_reg ? rem_reg : tgarle_pkg::RUN_W'(1);
        q_data.packet_ends = repeat_reg || (rem_reg <= tgarle_pkg::RUN_W'(1));
        q_push             = accept && !clear && (phase_reg == PH_PIXEL) && last_byte;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        rem_next    = rem_reg;
        repeat_next = repeat_reg;
        idx_next    = idx_reg;
        asm_next    = asm_reg;
        if (clear)
        begin
            phase_next  = PH_HEADER;
            rem_next    = '0;
            repeat_next = 1'b0;
            idx_next    = '0;
            asm_next    = '0;
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    // Top bit set opens a repeat packet
                    repeat_next = b[7];
                    rem_next    = b[7] ? (b - tgarle_pkg::REPEAT_BASE)
                                       : (b + tgarle_pkg::BYTE_W'(1));
                    idx_next    = '0;
                    asm_next    = '0;
                    phase_next  = PH_PIXEL;
                end
                PH_PIXEL:
                begin
                    if (last_byte)
                    begin
                        asm_next = '0;
                        idx_next = '0;
                        if (q_data.packet_ends)
                        begin
                            phase_next = PH_HEADER;
                            rem_next   = '0;
                        end
                        else
                        begin
                            rem_next = rem_reg - tgarle_pkg::RUN_W'(1);
                        end
                    end
                    else
                    begin
                        asm_next = merged;
                        idx_next = idx_reg + 2'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            rem_reg    <= '0;
            repeat_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            rem_reg    <= rem_next;
            repeat_reg <= repeat_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
    end

    a_idx_in_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= tgarle_pkg::last_byte_idx(pixel_format))
        else $error("byte index past end of pixel");

endmodule

[sv/tgarle_back.sv]
`timescale 1ns / 1ps

module tgarle_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tgarle_pkg::ctl_t         ctl,
    input  logic                     q_valid,
    input  tgarle_pkg::pix_evt_t     q_data,
    output logic                     q_pop,
    tgarle_pixel_if.source           pixels
);

    localparam int unsigned COUNT_W = tgarle_pkg::COUNT_W;
    localparam int unsigned RUN_W   = tgarle_pkg::RUN_W;

    logic                          out_valid_reg, out_valid_next;
    logic [tgarle_pkg::PIX_W-1:0]  pixel_reg;
    logic [RUN_W-1:0]              run_reg;
    logic                          done_reg, err_reg;
    logic [COUNT_W-1:0]            remaining_reg, remaining_next;
    logic                          halted_reg, halted_next;
    logic                          out_free, load;
    logic [COUNT_W-1:0]            run_wide;
    logic                          run_gt, run_eq;
    logic [RUN_W-1:0]              emit_run;
    logic                          done, err;

    assign out_free = !out_valid_reg || pixels.ready;
    // Drop words once halted; otherwise move one word when the output frees
    assign q_pop    = q_valid && !ctl.clear && (halted_reg || out_free);
    assign load     = q_valid && !ctl.clear && !halted_reg && out_free;

    assign run_wide = COUNT_W'(q_data.run);
    assign run_gt   = run_wide > remaining_reg;
    assign run_eq   = run_wide == remaining_reg;
    assign emit_run = run_gt ? remaining_reg[RUN_W-1:0] : q_data.run;
    assign done     = run_eq && q_data.packet_ends;
    assign err      = run_gt || (run_eq && !q_data.packet_ends);

    assign pixels.valid          = out_valid_reg;
    assign pixels.pixel_value    = pixel_reg;
    assign pixels.run_length     = run_reg;
    assign pixels.image_done     = done_reg;
    assign pixels.overflow_error = err_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        remaining_next = remaining_reg;
        halted_next    = halted_reg;
        if (ctl.clear)
        begin
            out_valid_next = 1'b0;
            remaining_next = ctl.count;
            halted_next    = 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_next = 1'b1;
                remaining_next = remaining_reg - COUNT_W'(emit_run);
                halted_next    = done || err;
            end
            else if (pixels.ready)
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            remaining_reg <= tgarle_pkg::COUNT_RESET;
            halted_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            remaining_reg <= remaining_next;
            halted_reg    <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_reg <= q_data.pixel;
            run_reg   <= emit_run;
            done_reg  <= done;
            err_reg   <= err;
        end
    end

    a_done_xor_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_reg && err_reg))
        else $error("pixel word flags both done and overflow");

    a_halt_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !load)
        else $error("pixel word loaded after halt");

    a_zero_run_is_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (run_reg == '0)) |-> err_reg)
        else $error("zero run length without overflow");

endmodule

[sv/tga_rle_pixel_decoder.sv]
`timescale 1ns / 1ps

// TGA run-length pixel stream decoder.
// stream: one encoded byte per word (valid/ready). A header byte below 128
//   opens a raw packet of header+1 pixels, 128 and above a repeat packet of
//   header-127 copies of a single pixel. Pixels are 1, 3 or 4 bytes.
// pixels: one word per completed pixel carrying the pixel bytes (first byte
//   in bits 7:0), its run length, and the image_done / overflow_error flags.
//   Runs are reported, never expanded.
// cfg: register writes (0 pixel_count, 1 pixel_format), always ready. A
//   write to a known register restarts decoding; write only while idle.
// Throughput: one stream byte per cycle while the queue has space. A pixel
//   word passes through a queue slot, which captures it when its last byte is
//   taken, and then the back stage output register, which loads it once free.
// The front and back are split by a short queue; when the pixels receiver
//   stalls, the queue fills and stream ready drops only once it is full.
// After image_done or overflow_error every byte is accepted and dropped
//   until reset or a write to a known configuration register.
// Reset: pixel_count 1, pixel_format RGBA, decoder waiting for a header.
module tga_rle_pixel_decoder #(
    parameter int unsigned QUEUE_DEPTH = tgarle_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    tgarle_stream_if.sink   stream,
    tgarle_pixel_if.source  pixels,
    tgarle_cfg_if.sink      cfg
);

    logic [tgarle_pkg::COUNT_W-1:0] pixel_count_reg, pixel_count_next;
    logic [tgarle_pkg::FMT_W-1:0]   pixel_format_reg, pixel_format_next;
    tgarle_pkg::ctl_t               ctl;
    logic                           cfg_write;

    logic                           q_space, q_push, q_pop, q_valid;
    tgarle_pkg::pix_evt_t           push_evt, pop_evt;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    // Decode register writes; an unknown index does nothing
    always_comb
    begin
        pixel_count_next  = pixel_count_reg;
        pixel_format_next = pixel_format_reg;
        ctl.clear         = 1'b0;
        if (cfg_write)
        begin
            case (cfg.index)
                tgarle_pkg::REG_PIXEL_COUNT:
                begin
                    pixel_count_next = cfg.data[tgarle_pkg::COUNT_W-1:0];
                    ctl.clear        = 1'b1;
                end
                tgarle_pkg::REG_PIXEL_FORMAT:
                begin
                    pixel_format_next = cfg.data[tgarle_pkg::FMT_W-1:0];
                    ctl.clear         = 1'b1;
                end
                default:
                begin
                    ctl.clear = 1'b0;
                end
            endcase
        end
        // Hand the back stage the count that takes effect with this write
        ctl.count = pixel_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg  <= tgarle_pkg::COUNT_RESET;
            pixel_format_reg <= tgarle_pkg::FORMAT_RESET;
        end
        else
        begin
            pixel_count_reg  <= pixel_count_next;
            pixel_format_reg <= pixel_format_next;
        end
    end

    // Front: take bytes, parse headers, assemble pixels
    tgarle_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (ctl.clear),
        .pixel_format (pixel_format_reg),
        .stream       (stream),
        .q_space      (q_space),
        .q_push       (q_push),
        .q_data       (push_evt)
    );

    // Queue of completed pixels between front and back
    tgarle_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W ($bits(tgarle_pkg::pix_evt_t))
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (ctl.clear),
        .push      (q_push),
        .push_data (push_evt),
        .space     (q_space),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (pop_evt)
    );

    // Back: clip runs to the pixels still missing, flag end, drive output
    tgarle_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .q_valid (q_valid),
        .q_data  (pop_evt),
        .q_pop   (q_pop),
        .pixels  (pixels)
    );

endmodule
